@@ rtl/lwts_pkg.sv @@
// Package of the write-back tag store: field widths, action codes, controller states
// and the command and status structs between controller and datapath. No dependencies.
package lwts_pkg;

  localparam int unsigned LinesDef      = 16;
  localparam int unsigned LineBytesDef  = 64;
  localparam int unsigned StreamBitsDef = 8;
  localparam int unsigned MaxResults    = 16;
  localparam int unsigned AddrW         = 32;
  localparam int unsigned StreamW       = 8;
  localparam int unsigned WayW          = 4;
  localparam int unsigned OffW          = 6;
  localparam int unsigned ActW          = 3;

  typedef enum logic [ActW-1:0] {
    ACT_READ     = 3'd0,
    ACT_WRITE    = 3'd1,
    ACT_FLUSH_S  = 3'd2,
    ACT_FLUSH_A  = 3'd3,
    ACT_INVAL_S  = 3'd4,
    ACT_INVAL_A  = 3'd5,
    ACT_CLEAR_S  = 3'd6,
    ACT_CLEAR_A  = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_WALK,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;      // capture the input transaction
    logic lookup;    // register the tag compare and victim choice
    logic update;    // commit the access and register its result
    logic walk_clr;  // reset the maintenance walk
    logic walk_step; // handle the current line of the walk
  } cmd_t;

  typedef struct packed {
    logic is_access;
    logic walk_emit; // current walk line produces a result
    logic walk_last; // current walk line gives the final result of the walk
    logic walk_more; // a later line needs handling: dirty under the cap, or any selected one when dropping
  } sts_t;

endpackage

@@ rtl/lwts_if.sv @@
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface lwts_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/lwts_ctrl.sv @@
// Controller state machine of the tag store: sequences lookup, update and the
// maintenance walk. Depends on lwts_pkg.
module lwts_ctrl import lwts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_free_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic out_push_o,
  output logic out_last_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_LOOKUP;
      ST_LOOKUP: state_d = sts_i.is_access ? ST_UPDATE : ST_WALK;
      ST_UPDATE: if (out_free_i) state_d = ST_IDLE;
      ST_WALK: begin
        if (sts_i.walk_emit) begin
          if (out_free_i) state_d = sts_i.walk_more ? ST_WALK : ST_IDLE;
        end else if (!sts_i.walk_more) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_push_o = 1'b0;
    out_last_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_LOOKUP: begin
        cmd_o.lookup   = 1'b1;
        cmd_o.walk_clr = 1'b1;
      end
      ST_UPDATE: begin
        cmd_o.update = out_free_i;
        out_push_o   = out_free_i;
        out_last_o   = 1'b1;
      end
      ST_WALK: begin
        // hold on a result line until the output register is free
        cmd_o.walk_step = !sts_i.walk_emit || out_free_i;
        out_push_o      = sts_i.walk_emit && out_free_i;
        out_last_o      = sts_i.walk_last;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/lwts_dp.sv @@
// Datapath of the tag store: line state, tag compare, recency ranks, maintenance
// walk and result assembly. Depends on lwts_pkg.
module lwts_dp import lwts_pkg::*; #(
  parameter int unsigned LINES       = LinesDef,
  parameter int unsigned LINE_BYTES  = LineBytesDef,
  parameter int unsigned STREAM_BITS = StreamBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [ActW-1:0]    action_i,
  input  logic [StreamW-1:0] stream_id_i,
  input  logic [AddrW-1:0]   byte_address_i,
  output logic               r_hit_o,
  output logic [WayW-1:0]    r_way_o,
  output logic [OffW-1:0]    r_byte_offset_o,
  output logic               r_writeback_o,
  output logic [StreamW-1:0] r_writeback_stream_o,
  output logic [AddrW-1:0]   r_writeback_line_address_o
);

  localparam int unsigned SlotW  = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned OffB   = $clog2(LINE_BYTES);
  localparam int unsigned TagW   = AddrW - OffB;
  localparam int unsigned CntW   = $clog2(MaxResults + 1);

  logic [LINES-1:0]       valid_q, dirty_q;
  logic [STREAM_BITS-1:0] stream_q [LINES];
  logic [TagW-1:0]        tag_q    [LINES];
  logic [SlotW-1:0]       rank_q   [LINES];

  logic [ActW-1:0]        act_q;
  logic [STREAM_BITS-1:0] key_q;
  logic [AddrW-1:0]       addr_q;
  logic                   found_q;
  logic [SlotW-1:0]       way_q;
  logic [SlotW-1:0]       idx_q;
  logic [CntW-1:0]        cnt_q;

  logic [TagW-1:0] tag_in;
  assign tag_in = addr_q[AddrW-1:OffB];

  // match vector and victim (slot holding the highest rank)
  logic [LINES-1:0] match;
  logic             found_c;
  logic [SlotW-1:0] hit_way_c, vic_way_c;
  always_comb begin
    found_c   = 1'b0;
    hit_way_c = '0;
    vic_way_c = '0;
    for (int i = 0; i < LINES; i++) begin
      match[i] = valid_q[i] && stream_q[i] == key_q && tag_q[i] == tag_in;
      if (rank_q[i] == SlotW'(LINES - 1)) vic_way_c = SlotW'(i);
    end
    for (int i = LINES - 1; i >= 0; i--) begin
      if (match[i]) begin
        found_c   = 1'b1;
        hit_way_c = SlotW'(i);
      end
    end
  end

  // maintenance decode
  logic all_c, do_wb_c, drop_c;
  assign all_c   = act_q[0];
  assign do_wb_c = (act_q == ACT_FLUSH_S) || (act_q == ACT_FLUSH_A) ||
                   (act_q == ACT_CLEAR_S) || (act_q == ACT_CLEAR_A);
  assign drop_c  = act_q[2];

  logic [LINES-1:0] sel, emitv;
  logic             cap_ok;
  assign cap_ok = cnt_q < CntW'(MaxResults);
  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      sel[i]   = valid_q[i] && (all_c || stream_q[i] == key_q);
      emitv[i] = sel[i] && do_wb_c && dirty_q[i];
    end
  end

  // later emitting line, with the cap applied after this one
  logic more_emit, more_any;
  always_comb begin
    more_emit = 1'b0;
    more_any  = 1'b0;
    for (int i = 0; i < LINES; i++) begin
      if (SlotW'(i) > idx_q) begin
        if (emitv[i]) more_emit = 1'b1;
        if (sel[i]) more_any = 1'b1;
      end
    end
  end

  logic cur_emit, cap_after, cur_drop;
  assign cur_emit  = emitv[idx_q] && cap_ok;
  // a dirty line beyond the cap stays valid and dirty, also under clear
  assign cur_drop  = sel[idx_q] && drop_c && !(emitv[idx_q] && !cap_ok);
  assign cap_after = (cnt_q + CntW'(cur_emit)) < CntW'(MaxResults);
  assign sts_o.is_access = (act_q == ACT_READ) || (act_q == ACT_WRITE);
  assign sts_o.walk_emit = cur_emit;
  assign sts_o.walk_last = !(more_emit && cap_after);
  assign sts_o.walk_more = (idx_q != SlotW'(LINES - 1)) &&
                           ((more_emit && cap_after) || (drop_c && more_any));

  logic [SlotW-1:0] w_c;
  assign w_c = found_q ? way_q : way_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      for (int i = 0; i < LINES; i++) begin
        stream_q[i] <= '0;
        tag_q[i]    <= '0;
        rank_q[i]   <= SlotW'(i);
      end
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.walk_clr) begin
        idx_q <= '0;
        cnt_q <= '0;
      end
      if (cmd_i.update) begin
        for (int i = 0; i < LINES; i++) begin
          if (SlotW'(i) == w_c) begin
            rank_q[i] <= '0;
          end else if (rank_q[i] < rank_q[w_c]) begin
            rank_q[i] <= rank_q[i] + 1'b1;
          end
        end
        if (!found_q) begin
          valid_q[w_c]  <= 1'b1;
          dirty_q[w_c]  <= (act_q == ACT_WRITE);
          stream_q[w_c] <= key_q;
          tag_q[w_c]    <= tag_in;
        end else if (act_q == ACT_WRITE) begin
          dirty_q[w_c] <= 1'b1;
        end
      end
      if (cmd_i.walk_step) begin
        if (cur_emit) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (cur_emit || cur_drop) begin
          dirty_q[idx_q] <= 1'b0;
        end
        if (cur_drop) begin
          valid_q[idx_q] <= 1'b0;
        end
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_i;
      key_q  <= STREAM_BITS'(stream_id_i);
      addr_q <= byte_address_i;
    end
    if (cmd_i.lookup) begin
      found_q <= found_c;
      way_q   <= found_c ? hit_way_c : vic_way_c;
    end
  end

  // result fields for the current step
  logic [TagW-1:0]        r_tag;
  logic [STREAM_BITS-1:0] r_str;
  logic                   r_wb;
  logic [SlotW-1:0]       r_slot;
  always_comb begin
    if (sts_o.is_access) begin
      r_slot          = way_q;
      r_hit_o         = found_q;
      r_wb            = !found_q && valid_q[way_q] && dirty_q[way_q];
      r_byte_offset_o = OffW'(addr_q & AddrW'(LINE_BYTES - 1));
    end else begin
      r_slot          = idx_q;
      r_hit_o         = 1'b0;
      r_wb            = 1'b1;
      r_byte_offset_o = '0;
    end
    r_tag                      = tag_q[r_slot];
    r_str                      = stream_q[r_slot];
    r_way_o                    = WayW'(r_slot);
    r_writeback_o              = r_wb;
    r_writeback_stream_o       = r_wb ? StreamW'(r_str) : '0;
    r_writeback_line_address_o = r_wb ? {r_tag, OffB'(0)} : '0;
  end

endmodule

@@ rtl/lru_writeback_tag_store.sv @@
// Top level of the fully associative write-back tag store with LRU replacement.
// Depends on lwts_pkg, lwts_if, lwts_ctrl and lwts_dp.
//
// A read or write access goes from acceptance to a registered result through
// capture, associative compare and victim choice across all lines, then the
// commit of tags, dirty bit and recency ranks once the output register is free.
// Maintenance actions walk the lines one per cycle after capture and lookup,
// holding on a result line while the output register is busy, and stop after the
// last line that needs handling; each written-back line gives one transaction.
// A new transaction is taken once the previous one has been handed to the output
// register, which holds a result while the sink is busy.
module lru_writeback_tag_store import lwts_pkg::*; #(
  parameter int unsigned LINES       = LinesDef,
  parameter int unsigned LINE_BYTES  = LineBytesDef,
  parameter int unsigned STREAM_BITS = StreamBitsDef
) (
  input logic clk_i,
  input logic rst_ni,
  lwts_if.sink   req_i,
  lwts_if.source rsp_o
);

  cmd_t cmd;
  sts_t sts;
  logic push, last, out_free;

  logic               r_hit, r_wb, r_fill;
  logic [WayW-1:0]    r_way;
  logic [OffW-1:0]    r_off;
  logic [StreamW-1:0] r_wbs;
  logic [AddrW-1:0]   r_wba;

  logic               ov_q;
  logic               o_hit_q, o_wb_q, o_fill_q, o_last_q;
  logic [WayW-1:0]    o_way_q;
  logic [OffW-1:0]    o_off_q;
  logic [StreamW-1:0] o_wbs_q;
  logic [AddrW-1:0]   o_wba_q;

  assign out_free = !ov_q || rsp_o.ready;

  lwts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .out_push_o (push),
    .out_last_o (last)
  );

  lwts_dp #(
    .LINES       (LINES),
    .LINE_BYTES  (LINE_BYTES),
    .STREAM_BITS (STREAM_BITS)
  ) u_dp (
    .clk_i                      (clk_i),
    .rst_ni                     (rst_ni),
    .cmd_i                      (cmd),
    .sts_o                      (sts),
    .action_i                   (req_i.payload.action),
    .stream_id_i                (req_i.payload.stream_id),
    .byte_address_i             (req_i.payload.byte_address),
    .r_hit_o                    (r_hit),
    .r_way_o                    (r_way),
    .r_byte_offset_o            (r_off),
    .r_writeback_o              (r_wb),
    .r_writeback_stream_o       (r_wbs),
    .r_writeback_line_address_o (r_wba)
  );

  assign r_fill = sts.is_access && !r_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (push) begin
      ov_q <= 1'b1;
    end else if (rsp_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      o_hit_q  <= r_hit;
      o_way_q  <= r_way;
      o_off_q  <= r_off;
      o_wb_q   <= r_wb;
      o_wbs_q  <= r_wbs;
      o_wba_q  <= r_wba;
      o_fill_q <= r_fill;
      o_last_q <= last;
    end
  end

  assign rsp_o.valid                          = ov_q;
  assign rsp_o.payload.hit                    = o_hit_q;
  assign rsp_o.payload.way                    = o_way_q;
  assign rsp_o.payload.byte_offset            = o_off_q;
  assign rsp_o.payload.writeback              = o_wb_q;
  assign rsp_o.payload.writeback_stream       = o_wbs_q;
  assign rsp_o.payload.writeback_line_address = o_wba_q;
  assign rsp_o.payload.fill                   = o_fill_q;
  assign rsp_o.payload.last                   = o_last_q;

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free) else $error("result pushed over a held one");
  a_hit_nofill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.payload.hit) |-> (!rsp_o.payload.fill && !rsp_o.payload.writeback))
    else $error("hit reported with fill or writeback");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready) else $error("back-to-back accept");

endmodule

@@ tb/lru_writeback_tag_store_test.sv @@
// Testbench of the write-back tag store: drives accesses and maintenance actions,
// predicts every result in a scoreboard class. Depends on lwts_pkg, lwts_if and the RTL.
`timescale 1ns / 100ps

module lru_writeback_tag_store_test;
  import lwts_pkg::*;

  localparam int unsigned NumLines  = 16;
  localparam int unsigned TagW      = AddrW - OffW;
  localparam int unsigned NumRandom = 195;

  typedef struct packed {
    action_e            action;
    logic [StreamW-1:0] stream_id;
    logic [AddrW-1:0]   byte_address;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [WayW-1:0]    way;
    logic [OffW-1:0]    byte_offset;
    logic               writeback;
    logic [StreamW-1:0] writeback_stream;
    logic [AddrW-1:0]   writeback_line_address;
    logic               fill;
    logic               last;
  } rsp_t;

  class tag_store_scoreboard;
    logic               valid_q [NumLines];
    logic               dirty_q [NumLines];
    logic [StreamW-1:0] stream_q[NumLines];
    logic [TagW-1:0]    tag_q   [NumLines];
    int unsigned        rank_q  [NumLines];
    rsp_t               expected_q[$];
    int unsigned        errors;
    int unsigned        n_results;
    int unsigned        n_hits;
    int unsigned        n_writebacks;

    function new();
      for (int i = 0; i < NumLines; i++) begin
        valid_q[i]  = 1'b0;
        dirty_q[i]  = 1'b0;
        stream_q[i] = '0;
        tag_q[i]    = '0;
        rank_q[i]   = i;
      end
      errors = 0;
      n_results = 0;
      n_hits = 0;
      n_writebacks = 0;
    endfunction

    function void promote(int w);
      int unsigned old;
      old = rank_q[w];
      for (int i = 0; i < NumLines; i++)
        if (rank_q[i] < old) rank_q[i]++;
      rank_q[w] = 0;
    endfunction

    // Work out the results of one accepted transaction and queue them.
    function void note_request(req_t r);
      rsp_t        res;
      logic [TagW-1:0] tag;
      int          w;
      bit          found;
      bit          all_lines;
      bit          do_wb;
      bit          drop;
      int          n;
      tag = r.byte_address[AddrW-1:OffW];
      res = '0;
      if (r.action == ACT_READ || r.action == ACT_WRITE) begin
        found = 1'b0;
        w = 0;
        for (int i = 0; i < NumLines; i++)
          if (!found && valid_q[i] && stream_q[i] == r.stream_id && tag_q[i] == tag) begin
            w = i;
            found = 1'b1;
          end
        res.byte_offset = r.byte_address[OffW-1:0];
        res.last = 1'b1;
        if (found) begin
          if (r.action == ACT_WRITE) dirty_q[w] = 1'b1;
          res.hit = 1'b1;
        end else begin
          for (int i = 0; i < NumLines; i++)
            if (rank_q[i] > rank_q[w]) w = i;
          if (valid_q[w] && dirty_q[w]) begin
            res.writeback = 1'b1;
            res.writeback_stream = stream_q[w];
            res.writeback_line_address = {tag_q[w], {OffW{1'b0}}};
          end
          res.fill = 1'b1;
          valid_q[w]  = 1'b1;
          dirty_q[w]  = (r.action == ACT_WRITE);
          stream_q[w] = r.stream_id;
          tag_q[w]    = tag;
        end
        res.way = WayW'(w);
        promote(w);
        expected_q.push_back(res);
      end else begin
        all_lines = r.action[0];
        do_wb = r.action inside {ACT_FLUSH_S, ACT_FLUSH_A, ACT_CLEAR_S, ACT_CLEAR_A};
        drop = r.action inside {ACT_INVAL_S, ACT_INVAL_A, ACT_CLEAR_S, ACT_CLEAR_A};
        n = 0;
        for (int i = 0; i < NumLines; i++) begin
          if (!valid_q[i] || (!all_lines && stream_q[i] != r.stream_id)) continue;
          if (do_wb && dirty_q[i]) begin
            if (n >= MaxResults) continue;
            res = '0;
            res.way = WayW'(i);
            res.writeback = 1'b1;
            res.writeback_stream = stream_q[i];
            res.writeback_line_address = {tag_q[i], {OffW{1'b0}}};
            expected_q.push_back(res);
            n++;
            dirty_q[i] = 1'b0;
          end
          if (drop) begin
            valid_q[i] = 1'b0;
            dirty_q[i] = 1'b0;
          end
        end
        if (n > 0) expected_q[$].last = 1'b1;
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: %p", $time, got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      n_results++;
      if (exp_r.hit) n_hits++;
      if (exp_r.writeback) n_writebacks++;
      if (got.hit !== exp_r.hit)
        $display("%0t: hit exp %0d got %0d", $time, exp_r.hit, got.hit);
      if (got.way !== exp_r.way)
        $display("%0t: way exp %0d got %0d", $time, exp_r.way, got.way);
      if (got.byte_offset !== exp_r.byte_offset)
        $display("%0t: byte_offset exp %0d got %0d", $time, exp_r.byte_offset,
                 got.byte_offset);
      if (got.writeback !== exp_r.writeback)
        $display("%0t: writeback exp %0d got %0d", $time, exp_r.writeback, got.writeback);
      if (got.writeback_stream !== exp_r.writeback_stream)
        $display("%0t: writeback_stream exp %0h got %0h", $time,
                 exp_r.writeback_stream, got.writeback_stream);
      if (got.writeback_line_address !== exp_r.writeback_line_address)
        $display("%0t: writeback_line_address exp %h got %h", $time,
                 exp_r.writeback_line_address, got.writeback_line_address);
      if (got.fill !== exp_r.fill)
        $display("%0t: fill exp %0d got %0d", $time, exp_r.fill, got.fill);
      if (got.last !== exp_r.last)
        $display("%0t: last exp %0d got %0d", $time, exp_r.last, got.last);
      if (got !== exp_r) errors++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  tag_store_scoreboard sb;
  bit hold_off_req;
  int unsigned n_sent;

  lwts_if #(.payload_t(req_t)) req_if ();
  lwts_if #(.payload_t(rsp_t)) rsp_if ();

  lru_writeback_tag_store u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #5ms;
    $display("lru_writeback_tag_store_test: errors");
    $finish;
  end

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned n;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_if.ready <= 1'b0;
        for (int c = 0; c < 300; c++) @(posedge clk_i);
      end
      n = gap_len();
      if (n > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i)
    if (rst_ni && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.payload);

  task automatic send(input action_e act, input logic [StreamW-1:0] sid,
                      input logic [AddrW-1:0] addr);
    req_t r;
    int unsigned n;
    r.action = act;
    r.stream_id = sid;
    r.byte_address = addr;
    n = gap_len();
    if (n > 0) begin
      req_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(r);
    n_sent++;
  endtask

  logic [StreamW-1:0] stream_pool[4];
  logic [TagW-1:0]    tag_pool[24];

  task automatic send_random();
    int unsigned p;
    action_e act;
    logic [AddrW-1:0] addr;
    logic [StreamW-1:0] sid;
    p = $urandom_range(99);
    sid = stream_pool[$urandom_range(3)];
    addr = {tag_pool[$urandom_range(23)], OffW'($urandom)};
    if (p < 8) begin
      sid = StreamW'($urandom);
      addr = $urandom;
    end
    if (p < 86) act = ($urandom_range(1)) ? ACT_WRITE : ACT_READ;
    else act = action_e'($urandom_range(7, 2));
    send(act, sid, addr);
  endtask

  initial begin
    sb = new();
    hold_off_req = 1'b0;
    n_sent = 0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    for (int i = 0; i < 4; i++) stream_pool[i] = StreamW'($urandom);
    stream_pool[0] = '0;
    stream_pool[1] = '1;
    for (int i = 0; i < 24; i++) tag_pool[i] = TagW'($urandom);
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, hits, dirty eviction, every maintenance action.
    send(ACT_READ, 8'h00, 32'h0000_0000);
    send(ACT_WRITE, 8'hff, 32'hffff_ffff);
    send(ACT_READ, 8'hff, 32'hffff_ffc0);
    send(ACT_WRITE, 8'h00, 32'h0000_003f);
    for (int i = 0; i < 14; i++) send(ACT_WRITE, 8'h5a, 32'(i) << 8);
    send(ACT_READ, 8'ha5, 32'h1234_5678);
    send(ACT_FLUSH_S, 8'h5a, '0);
    send(ACT_WRITE, 8'h5a, 32'h0000_0100);
    send(ACT_CLEAR_S, 8'h5a, '0);
    send(ACT_FLUSH_A, 8'h00, '0);
    send(ACT_INVAL_S, 8'ha5, '0);
    send(ACT_CLEAR_A, 8'h00, '0);
    send(ACT_INVAL_A, 8'h00, '0);

    for (int k = 0; k < NumRandom; k++) begin
      if (k == 100) hold_off_req = 1'b1;
      send_random();
    end
    req_if.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Sent %0d transactions; checked %0d results, %0d hits, %0d writebacks.",
             n_sent, sb.n_results, sb.n_hits, sb.n_writebacks);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("lru_writeback_tag_store_test: clean");
    else
      $display("lru_writeback_tag_store_test: errors");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/lwts_pkg.sv
rtl/lwts_if.sv
rtl/lwts_ctrl.sv
rtl/lwts_dp.sv
rtl/lru_writeback_tag_store.sv
tb/lru_writeback_tag_store_test.sv
